FILE: rtl/text_line_splitter_width_defines.svh
// ----------------------------------------------------------------------------
// Text line splitter assertion macros
// Shared helpers for the concurrent checks of the line splitter.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_SPLITTER_WIDTH_DEFINES_SVH
`define TEXT_LINE_SPLITTER_WIDTH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TLSW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlsw same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TLSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlsw next-cycle check failed");

`endif

FILE: rtl/tlsw_pkg.sv
// ----------------------------------------------------------------------------
// tlsw_pkg
// Constants and shared types of the text line splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package tlsw_pkg;

   localparam int OffsetBits = 24;
   localparam int OutOfsBits = 24;
   localparam int WidthBits  = 8;

   localparam logic [7:0] ByteEof = 8'h1A;
   localparam logic [7:0] ByteCr  = 8'h0D;
   localparam logic [7:0] ByteLf  = 8'h0A;
   localparam logic [7:0] ByteTab = 8'h09;

   localparam logic [WidthBits-1:0] WidthMax = 8'd255;
   localparam logic [WidthBits-1:0] TabWidth = 8'd8;

   // Bit n set: control byte n has no width.
   localparam logic [31:0] ZeroWidthSet = 32'hF8FC_C0FF;

   typedef struct packed {
      logic term;        // translated byte is CR, LF or ^Z
      logic tab;         // translated byte is a tab
      logic zero_width;  // style, swallowed or combining byte
      logic raw_cr;
      logic raw_lf;
      logic raw_eof;
   } tlsw_class_type;

endpackage

`default_nettype wire

FILE: rtl/tlsw_classify.sv
// ----------------------------------------------------------------------------
// tlsw_classify
// Sorts one buffer byte into terminator, tab, zero-width or base class.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsw_classify (
   input  wire logic [7:0]               raw_byte,
   input  wire logic [7:0]               translated_byte,
   output tlsw_pkg::tlsw_class_type      byte_class
);

   logic zero_width;

   always_comb begin
      case (translated_byte) inside
         [8'h00:8'h1F]: zero_width = tlsw_pkg::ZeroWidthSet[translated_byte[4:0]];
         8'hD1, [8'hD4:8'hDB], [8'hE7:8'hEE]: zero_width = 1'b1;
         default: zero_width = 1'b0;
      endcase
   end

   always_comb begin
      byte_class.term = (translated_byte == tlsw_pkg::ByteCr)
                     || (translated_byte == tlsw_pkg::ByteLf)
                     || (translated_byte == tlsw_pkg::ByteEof);
      byte_class.tab        = (translated_byte == tlsw_pkg::ByteTab);
      byte_class.zero_width = zero_width;
      byte_class.raw_cr     = (raw_byte == tlsw_pkg::ByteCr);
      byte_class.raw_lf     = (raw_byte == tlsw_pkg::ByteLf);
      byte_class.raw_eof    = (raw_byte == tlsw_pkg::ByteEof);
   end

endmodule

`default_nettype wire

FILE: rtl/tlsw_scan.sv
// ----------------------------------------------------------------------------
// tlsw_scan
// Line state, width counting and the result register of the splitter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_line_splitter_width_defines.svh"

module tlsw_scan #(
   parameter int OFFSET_BITS = tlsw_pkg::OffsetBits
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            item_valid,
   input  wire logic                            item_last,
   input  wire tlsw_pkg::tlsw_class_type        item_class,
   output logic                                 item_taken,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [tlsw_pkg::OutOfsBits-1:0]      rsp_line_offset,
   output logic [tlsw_pkg::OutOfsBits-1:0]      rsp_line_length,
   output logic [tlsw_pkg::WidthBits-1:0]       rsp_line_width,
   output logic [tlsw_pkg::WidthBits-1:0]       rsp_max_width,
   output logic                                 rsp_buffer_done
);

   localparam int WideBits = (OFFSET_BITS > tlsw_pkg::OutOfsBits) ?
                             OFFSET_BITS : tlsw_pkg::OutOfsBits;
   localparam int WB = tlsw_pkg::WidthBits;

   logic [OFFSET_BITS-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [WB-1:0]          col_ff, col_in, widest_ff, widest_in;
   logic                   pcr_ff, pcr_in, stopped_ff, stopped_in, any_ff, any_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [tlsw_pkg::OutOfsBits-1:0] ofs_ff, ofs_in, len_ff, len_in;
   logic [WB-1:0]          lwidth_ff, lwidth_in, mwidth_ff, mwidth_in;
   logic                   done_ff, done_in;

   logic [OFFSET_BITS-1:0] pos_inc, rpt_end, rpt_len;
   logic [WideBits-1:0]    start_wide, len_wide;
   logic [WB:0]            col_sum;
   logic [WB-1:0]          col_upd, rpt_col, widest_new;
   logic                   swallow, emit, out_free;

   always_comb begin
      pos_inc = pos_ff + OFFSET_BITS'(1);
      swallow = pcr_ff && item_class.raw_lf;

      if (item_class.tab) begin
         col_sum = {1'b0, col_ff} + {1'b0, tlsw_pkg::TabWidth};
      end else if (item_class.zero_width) begin
         col_sum = {1'b0, col_ff};
      end else begin
         col_sum = {1'b0, col_ff} + (WB+1)'(1);
      end
      col_upd = col_sum[WB] ? tlsw_pkg::WidthMax : col_sum[WB-1:0];

      // A terminator reports the line before it; a plain last byte includes itself.
      rpt_col    = item_class.term ? col_ff : col_upd;
      rpt_end    = item_class.term ? pos_ff : pos_inc;
      rpt_len    = rpt_end - start_ff;
      widest_new = (rpt_col > widest_ff) ? rpt_col : widest_ff;

      emit = !stopped_ff && !swallow &&
             (item_class.term || (item_last && ((pos_inc != start_ff) || !any_ff)));

      out_free   = !rsp_valid_ff || rsp_ready;
      item_taken = item_valid && (!emit || out_free);

      start_wide = WideBits'(start_ff);
      len_wide   = WideBits'(rpt_len);
   end

   always_comb begin
      pos_in     = pos_ff;
      start_in   = start_ff;
      col_in     = col_ff;
      widest_in  = widest_ff;
      pcr_in     = pcr_ff;
      stopped_in = stopped_ff;
      any_in     = any_ff;
      if (item_taken) begin
         if (item_last) begin
            pos_in     = '0;
            start_in   = '0;
            col_in     = '0;
            widest_in  = '0;
            pcr_in     = 1'b0;
            stopped_in = 1'b0;
            any_in     = 1'b0;
         end else if (stopped_ff) begin
            // drop bytes after ^Z
         end else if (swallow) begin
            pcr_in   = 1'b0;
            pos_in   = pos_inc;
            start_in = pos_inc;
         end else if (item_class.term) begin
            widest_in = widest_new;
            any_in    = 1'b1;
            if (item_class.raw_eof) begin
               stopped_in = 1'b1;
               pcr_in     = 1'b0;
            end else begin
               col_in   = '0;
               pcr_in   = item_class.raw_cr;
               pos_in   = pos_inc;
               start_in = pos_inc;
            end
         end else begin
            pcr_in = 1'b0;
            col_in = col_upd;
            pos_in = pos_inc;
         end
      end
   end

   always_comb begin
      ofs_in    = ofs_ff;
      len_in    = len_ff;
      lwidth_in = lwidth_ff;
      mwidth_in = mwidth_ff;
      done_in   = done_ff;
      if (item_taken && emit) begin
         rsp_valid_in = 1'b1;
         ofs_in    = start_wide[tlsw_pkg::OutOfsBits-1:0];
         len_in    = len_wide[tlsw_pkg::OutOfsBits-1:0];
         lwidth_in = rpt_col;
         mwidth_in = widest_new;
         done_in   = item_class.term ? (item_class.raw_eof || item_last) : 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         start_ff     <= '0;
         col_ff       <= '0;
         widest_ff    <= '0;
         pcr_ff       <= 1'b0;
         stopped_ff   <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         col_ff       <= col_in;
         widest_ff    <= widest_in;
         pcr_ff       <= pcr_in;
         stopped_ff   <= stopped_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ofs_ff    <= ofs_in;
      len_ff    <= len_in;
      lwidth_ff <= lwidth_in;
      mwidth_ff <= mwidth_in;
      done_ff   <= done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_offset = ofs_ff;
   assign rsp_line_length = len_ff;
   assign rsp_line_width  = lwidth_ff;
   assign rsp_max_width   = mwidth_ff;
   assign rsp_buffer_done = done_ff;

   `TLSW_ASSERT_IMPL(a_no_cr_after_eof, clock, reset, stopped_ff, !pcr_ff)
   `TLSW_ASSERT_IMPL(a_width_within_max, clock, reset, rsp_valid_ff, lwidth_ff <= mwidth_ff)
   `TLSW_ASSERT_IMPL(a_widest_needs_line, clock, reset, !any_ff, widest_ff == '0)
   `TLSW_ASSERT_NEXT(a_last_clears, clock, reset, item_taken && item_last,
      (pos_ff == '0) && (start_ff == '0) && (col_ff == '0) && !any_ff)

endmodule

`default_nettype wire

FILE: rtl/text_line_splitter_width.sv
// ----------------------------------------------------------------------------
// text_line_splitter_width
// Splits a streamed text buffer into lines with offset, length and width.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (req_) carry one buffer byte each, raw and translated, with
//   req_last_byte marking the final byte. Result beats (rsp_) carry one line:
//   start offset, length without terminator, visible width, running maximum
//   width and a buffer-done flag. CR, LF and CRLF end a line; ^Z ends the
//   buffer and later bytes up to the last one are dropped.
//   From input beat to result beat a byte passes one input register and one
//   result register, with the line state updated as a byte leaves the
//   input register. One byte per cycle is taken continuously while the
//   result side keeps up; a byte that yields no line passes even while a
//   result is waiting.
//   When the receiver stalls, the result register holds its beat and the
//   next line-producing byte waits in the input register, so req_ready falls
//   only when both are full.
//   Synchronous reset clears the line state and empties both registers; the
//   state also returns to zero after every last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_splitter_width #(
   parameter int OFFSET_BITS = tlsw_pkg::OffsetBits
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_raw_byte,
   input  wire logic [7:0]                      req_translated_byte,
   input  wire logic                            req_last_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [tlsw_pkg::OutOfsBits-1:0]      rsp_line_offset,
   output logic [tlsw_pkg::OutOfsBits-1:0]      rsp_line_length,
   output logic [tlsw_pkg::WidthBits-1:0]       rsp_line_width,
   output logic [tlsw_pkg::WidthBits-1:0]       rsp_max_width,
   output logic                                 rsp_buffer_done
);

   logic        hold_valid_ff, hold_valid_in;
   logic [7:0]  raw_ff, raw_in, xlat_ff, xlat_in;
   logic        last_ff, last_in;
   logic        item_taken;
   tlsw_pkg::tlsw_class_type byte_class;

   always_comb begin
      req_ready = !hold_valid_ff || item_taken;
      raw_in    = raw_ff;
      xlat_in   = xlat_ff;
      last_in   = last_ff;
      if (req_valid && req_ready) begin
         hold_valid_in = 1'b1;
         raw_in  = req_raw_byte;
         xlat_in = req_translated_byte;
         last_in = req_last_byte;
      end else begin
         hold_valid_in = hold_valid_ff && !item_taken;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      xlat_ff <= xlat_in;
      last_ff <= last_in;
   end

   tlsw_classify u_classify (
      .raw_byte        (raw_ff),
      .translated_byte (xlat_ff),
      .byte_class      (byte_class)
   );

   tlsw_scan #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (hold_valid_ff),
      .item_last       (last_ff),
      .item_class      (byte_class),
      .item_taken      (item_taken),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_line_offset (rsp_line_offset),
      .rsp_line_length (rsp_line_length),
      .rsp_line_width  (rsp_line_width),
      .rsp_max_width   (rsp_max_width),
      .rsp_buffer_done (rsp_buffer_done)
   );

endmodule

`default_nettype wire

FILE: test/text_line_splitter_width_check.sv
// ----------------------------------------------------------------------------
// Line splitter result checker
// Watches the byte and line channels of the splitter, predicts every line
// from the accepted bytes and compares each line beat against the oldest
// prediction, field by field. Counts mismatches for the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_line_splitter_width_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_raw_byte,
   input  logic [7:0]                      req_translated_byte,
   input  logic                            req_last_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [tlsw_pkg::OutOfsBits-1:0] rsp_line_offset,
   input  logic [tlsw_pkg::OutOfsBits-1:0] rsp_line_length,
   input  logic [tlsw_pkg::WidthBits-1:0]  rsp_line_width,
   input  logic [tlsw_pkg::WidthBits-1:0]  rsp_max_width,
   input  logic                            rsp_buffer_done,
   output int                              mismatches,
   output int                              lines_owed
);

   // Thai combining marks of zero width
   localparam logic [7:0] MarkSingle = 8'hD1;
   localparam logic [7:0] MarkLoA    = 8'hD4;
   localparam logic [7:0] MarkHiA    = 8'hDB;
   localparam logic [7:0] MarkLoB    = 8'hE7;
   localparam logic [7:0] MarkHiB    = 8'hEE;

   typedef struct packed {
      logic [tlsw_pkg::OutOfsBits-1:0] offset;
      logic [tlsw_pkg::OutOfsBits-1:0] length;
      logic [tlsw_pkg::WidthBits-1:0]  width;
      logic [tlsw_pkg::WidthBits-1:0]  widest;
      logic                            done;
   } line_report_type;

   line_report_type owed_lines[$];

   logic [tlsw_pkg::OffsetBits-1:0] byte_pos;
   logic [tlsw_pkg::OffsetBits-1:0] head_pos;
   logic [tlsw_pkg::WidthBits-1:0]  column;
   logic [tlsw_pkg::WidthBits-1:0]  widest_seen;
   logic                            cr_pending;
   logic                            eof_seen;
   logic                            any_line;
   int                              lines_seen;

   initial begin
      mismatches = 0;
      lines_owed = 0;
   end

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      $display("%0t: line %0d %s: got %0d, want %0d", $realtime, lines_seen, what, got, want);
      mismatches = mismatches + 1;
   endtask

   function automatic void clear_buffer_state();
      byte_pos    = '0;
      head_pos    = '0;
      column      = '0;
      widest_seen = '0;
      cr_pending  = 1'b0;
      eof_seen    = 1'b0;
      any_line    = 1'b0;
   endfunction

   function automatic bit has_no_width(input logic [7:0] b);
      if (b <= 8'h1F) return tlsw_pkg::ZeroWidthSet[b[4:0]];
      return b == MarkSingle || (b >= MarkLoA && b <= MarkHiA) || (b >= MarkLoB && b <= MarkHiB);
   endfunction

   function automatic void owe_line(input logic [tlsw_pkg::OffsetBits-1:0] end_pos,
                                    input logic done);
      line_report_type rec;
      if (column > widest_seen) widest_seen = column;
      rec.offset = tlsw_pkg::OutOfsBits'(head_pos);
      rec.length = tlsw_pkg::OutOfsBits'(end_pos - head_pos);
      rec.width  = column;
      rec.widest = widest_seen;
      rec.done   = done;
      owed_lines.push_back(rec);
      any_line = 1'b1;
   endfunction

   function automatic void split_byte(input logic [7:0] raw, input logic [7:0] xlat,
                                      input logic last);
      logic [tlsw_pkg::WidthBits:0] col_sum;
      if (eof_seen) begin
         if (last) clear_buffer_state();
         return;
      end
      // LF right after a CR terminator only advances the offset
      if (cr_pending && raw == tlsw_pkg::ByteLf) begin
         cr_pending = 1'b0;
         byte_pos   = byte_pos + 1'b1;
         head_pos   = byte_pos;
         if (last) clear_buffer_state();
         return;
      end
      cr_pending = 1'b0;
      if (xlat == tlsw_pkg::ByteLf || xlat == tlsw_pkg::ByteCr
          || xlat == tlsw_pkg::ByteEof) begin
         owe_line(byte_pos, last || raw == tlsw_pkg::ByteEof);
         if (last) begin
            clear_buffer_state();
         end else if (raw == tlsw_pkg::ByteEof) begin
            eof_seen = 1'b1;
         end else begin
            column     = '0;
            cr_pending = (raw == tlsw_pkg::ByteCr);
            byte_pos   = byte_pos + 1'b1;
            head_pos   = byte_pos;
         end
         return;
      end
      if (xlat == tlsw_pkg::ByteTab) col_sum = column + tlsw_pkg::TabWidth;
      else if (!has_no_width(xlat)) col_sum = column + 1'b1;
      else col_sum = {1'b0, column};
      column   = (col_sum > tlsw_pkg::WidthMax) ? tlsw_pkg::WidthMax
                                                : col_sum[tlsw_pkg::WidthBits-1:0];
      byte_pos = byte_pos + 1'b1;
      if (last) begin
         if (byte_pos != head_pos || !any_line) owe_line(byte_pos, 1'b1);
         clear_buffer_state();
      end
   endfunction

   always @(posedge clock) begin
      line_report_type want;
      if (reset) begin
         owed_lines.delete();
         clear_buffer_state();
         lines_seen = 0;
      end else begin
         if (req_valid && req_ready)
            split_byte(req_raw_byte, req_translated_byte, req_last_byte);
         if (rsp_valid && rsp_ready) begin
            if (owed_lines.size() == 0) begin
               flag_mismatch("beat with no line owed, offset", rsp_line_offset, 0);
            end else begin
               want = owed_lines.pop_front();
               if (rsp_line_offset !== want.offset)
                  flag_mismatch("offset", rsp_line_offset, want.offset);
               if (rsp_line_length !== want.length)
                  flag_mismatch("length", rsp_line_length, want.length);
               if (rsp_line_width !== want.width)
                  flag_mismatch("width", rsp_line_width, want.width);
               if (rsp_max_width !== want.widest)
                  flag_mismatch("max width", rsp_max_width, want.widest);
               if (rsp_buffer_done !== want.done)
                  flag_mismatch("buffer done", rsp_buffer_done, want.done);
            end
            lines_seen = lines_seen + 1;
         end
      end
      lines_owed <= owed_lines.size();
   end

endmodule

FILE: test/text_line_splitter_width_test.sv
// ----------------------------------------------------------------------------
// Line splitter testbench
// Feeds the splitter with directed buffers for the terminator, ^Z, swallowed
// LF and width corner cases, then with random buffers of mixed content,
// under random stalls on both sides, one long receiver hold-off and drain
// pauses. The checker module predicts and compares every line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_line_splitter_width_test;

   localparam int CycleLimit = 200_000;
   localparam int ItemTarget = 1850;
   localparam int IdlePct    = 19;
   localparam int HoldCycles = 120;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_raw_byte = '0;
   logic [7:0]                      req_translated_byte = '0;
   logic                            req_last_byte = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [tlsw_pkg::OutOfsBits-1:0] rsp_line_offset;
   logic [tlsw_pkg::OutOfsBits-1:0] rsp_line_length;
   logic [tlsw_pkg::WidthBits-1:0]  rsp_line_width;
   logic [tlsw_pkg::WidthBits-1:0]  rsp_max_width;
   logic                            rsp_buffer_done;

   int   mismatches;
   int   lines_owed;
   int   items_sent = 0;
   int   cycle_count = 0;
   int   hold_left = 0;
   logic hold_taken = 1'b0;
   logic hold_off_start = 1'b0;
   logic steady = 1'b0;
   logic burst = 1'b0;

   text_line_splitter_width uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_raw_byte        (req_raw_byte),
      .req_translated_byte (req_translated_byte),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_line_offset     (rsp_line_offset),
      .rsp_line_length     (rsp_line_length),
      .rsp_line_width      (rsp_line_width),
      .rsp_max_width       (rsp_max_width),
      .rsp_buffer_done     (rsp_buffer_done)
   );

   text_line_splitter_width_check checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_raw_byte        (req_raw_byte),
      .req_translated_byte (req_translated_byte),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_line_offset     (rsp_line_offset),
      .rsp_line_length     (rsp_line_length),
      .rsp_line_width      (rsp_line_width),
      .rsp_max_width       (rsp_max_width),
      .rsp_buffer_done     (rsp_buffer_done),
      .mismatches          (mismatches),
      .lines_owed          (lines_owed)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("text_line_splitter_width regression: fail");
         $finish;
      end
   end

   // Receiver: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_off_start && !hold_taken) begin
         rsp_ready  <= 1'b0;
         hold_left  <= HoldCycles;
         hold_taken <= 1'b1;
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 99) >= IdlePct);
      end
   end

   task automatic send_beat(input logic [7:0] raw, input logic [7:0] xlat, input logic last);
      if (!steady && !burst) begin
         while ($urandom_range(0, 99) < IdlePct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid           <= 1'b1;
      req_raw_byte        <= raw;
      req_translated_byte <= xlat;
      req_last_byte       <= last;
      do @(posedge clock); while (!req_ready);
      items_sent = items_sent + 1;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (lines_owed != 0) @(posedge clock);
   endtask

   function automatic void pick_byte(output logic [7:0] raw, output logic [7:0] xlat);
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) raw = 8'($urandom_range(8'h20, 8'h7E));
      else if (r < 55) raw = tlsw_pkg::ByteLf;
      else if (r < 63) raw = tlsw_pkg::ByteCr;
      else if (r < 70) raw = tlsw_pkg::ByteTab;
      else if (r < 76) raw = 8'($urandom_range(0, 8'h1F));
      else if (r < 82) raw = 8'($urandom_range(8'hD0, 8'hEF));
      else if (r < 90) raw = 8'($urandom_range(8'h80, 8'hFF));
      else if (r < 99) raw = 8'($urandom_range(0, 255));
      else raw = tlsw_pkg::ByteEof;
      xlat = raw;
      // translated value that may disagree with the raw one
      if (r >= 90 && r < 99) xlat = 8'($urandom_range(0, 255));
   endfunction

   task automatic send_buffer();
      int          r;
      int          len;
      bit          wide;
      logic [7:0]  raw;
      logic [7:0]  xlat;
      logic [7:0]  prev_raw;
      r        = $urandom_range(0, 99);
      wide     = (r >= 98);
      len      = (r < 85) ? $urandom_range(1, 24) :
                 (r < 98) ? $urandom_range(25, 80) : $urandom_range(40, 70);
      prev_raw = '0;
      for (int i = 0; i < len; i++) begin
         if (wide) begin
            raw  = $urandom_range(0, 1) ? tlsw_pkg::ByteTab : 8'($urandom_range(8'h21, 8'h7E));
            xlat = raw;
         end else if (prev_raw == tlsw_pkg::ByteCr && $urandom_range(0, 1)) begin
            raw  = tlsw_pkg::ByteLf;
            xlat = tlsw_pkg::ByteLf;
         end else begin
            pick_byte(raw, xlat);
         end
         send_beat(raw, xlat, i == len - 1);
         prev_raw = raw;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero width, base, tab, mark, CRLF, then a base byte and LF as the last byte
      send_beat(8'h00, 8'h00, 1'b0);
      send_beat(8'hFF, 8'hFF, 1'b0);
      send_beat(tlsw_pkg::ByteTab, tlsw_pkg::ByteTab, 1'b0);
      send_beat(8'hD1, 8'hD1, 1'b0);
      send_beat(tlsw_pkg::ByteCr, tlsw_pkg::ByteCr, 1'b0);
      send_beat(tlsw_pkg::ByteLf, tlsw_pkg::ByteLf, 1'b0);
      send_beat(8'h41, 8'h41, 1'b0);
      send_beat(tlsw_pkg::ByteLf, tlsw_pkg::ByteLf, 1'b1);
      // swallowed LF as the last byte: no line carries buffer done
      send_beat(tlsw_pkg::ByteCr, tlsw_pkg::ByteCr, 1'b0);
      send_beat(tlsw_pkg::ByteLf, tlsw_pkg::ByteLf, 1'b1);
      // ^Z ends the buffer, later bytes dropped
      send_beat(8'h41, 8'h41, 1'b0);
      send_beat(tlsw_pkg::ByteEof, tlsw_pkg::ByteEof, 1'b0);
      send_beat(8'h42, 8'h42, 1'b0);
      send_beat(tlsw_pkg::ByteCr, tlsw_pkg::ByteCr, 1'b1);
      // raw and translated disagree, then an open line at the last byte
      send_beat(tlsw_pkg::ByteEof, 8'h41, 1'b0);
      send_beat(8'h41, tlsw_pkg::ByteCr, 1'b0);
      send_beat(tlsw_pkg::ByteLf, 8'h41, 1'b0);
      send_beat(8'hEE, 8'hEE, 1'b1);
      // one-byte buffers: ^Z last, LF last, base last
      send_beat(tlsw_pkg::ByteEof, tlsw_pkg::ByteEof, 1'b1);
      send_beat(tlsw_pkg::ByteLf, tlsw_pkg::ByteLf, 1'b1);
      send_beat(8'h7F, 8'h7F, 1'b1);
      wait_drained();

      while (items_sent < 700) send_buffer();

      // pause until every line is out, then fill the block against a stalled receiver
      wait_drained();
      hold_off_start <= 1'b1;
      burst = 1'b1;
      for (int i = 0; i < 80; i++)
         send_beat(i[0] ? tlsw_pkg::ByteLf : 8'h61, i[0] ? tlsw_pkg::ByteLf : 8'h61,
                   i == 79);
      burst = 1'b0;

      while (items_sent < ItemTarget) begin
         steady <= (items_sent >= 1100 && items_sent < 1400);
         send_buffer();
      end
      steady <= 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && lines_owed == 0) begin
         $display("text_line_splitter_width regression: pass");
      end else begin
         $display("text_line_splitter_width regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tlsw_pkg.sv
rtl/tlsw_classify.sv
rtl/tlsw_scan.sv
rtl/text_line_splitter_width.sv
test/text_line_splitter_width_check.sv
test/text_line_splitter_width_test.sv
